// ===== src/dciq_pkg.sv =====
// shared constants, types and trial-setting function for the dc/iq calibration search
package dciq_pkg;

  localparam int COARSE_STEP = 8;
  localparam int IQ_RANGE    = 512;
  localparam int PASSES      = 4;
  localparam int LEVEL_WIDTH = 16;
  localparam int FINE_SPAN   = 8;
  localparam int GAIN_FULL   = 2047;
  localparam int RX_SIGN_BIT = 1 << 6;
  localparam int DC_SCALE_RX = 64;
  localparam int DC_SCALE_TX = 128;

  localparam int DC_W        = 8;
  localparam int IQ_W        = 10;
  localparam int GAIN_WORD_W = 11;
  localparam int DC_WORD_W   = 7;
  localparam int SWEEP_W     = $clog2(IQ_RANGE + COARSE_STEP) + 1;
  localparam int PASS_W      = $clog2(PASSES);
  localparam int STEP_W      = $clog2(COARSE_STEP + 1);

  // apb register map
  localparam int CFG_AW      = 3;
  localparam logic REG_DIRECTION = 1'b0;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_MEASURE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DC   = 2'd1,
    PH_IQ   = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t                    phase;
    logic [PASS_W-1:0]         pass;
    logic signed [SWEEP_W-1:0] sweep;
    logic signed [DC_W-1:0]    best_dc_i;
    logic signed [DC_W-1:0]    best_dc_q;
    logic signed [IQ_W-1:0]    best_gain;
    logic signed [IQ_W-1:0]    best_phase;
  } srch_state_t;

  typedef struct packed {
    logic signed [DC_W-1:0] dc_i;
    logic signed [DC_W-1:0] dc_q;
    logic signed [IQ_W-1:0] gain;
    logic signed [IQ_W-1:0] phase;
  } trial_t;

  // setting under test: sweep value on the active arm, best values elsewhere
  function automatic trial_t trial(srch_state_t s);
    trial_t t;
    t.dc_i  = s.best_dc_i;
    t.dc_q  = s.best_dc_q;
    t.gain  = s.best_gain;
    t.phase = s.best_phase;
    if (s.phase == PH_DC) begin
      t.gain  = '0;
      t.phase = '0;
      if (!s.pass[0]) begin
        t.dc_q = s.sweep[DC_W-1:0];
      end else begin
        t.dc_i = s.sweep[DC_W-1:0];
      end
    end else if (s.phase == PH_IQ) begin
      if (!s.pass[0]) begin
        t.gain = s.sweep[IQ_W-1:0];
      end else begin
        t.phase = s.sweep[IQ_W-1:0];
      end
    end
    return t;
  endfunction

endpackage

// ===== src/dciq_search.sv =====
// search state registers: best-level tracking, sweep stepping and pass sequencing
module dciq_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept_i,
  input  logic                                action_i,
  input  logic signed [dciq_pkg::LEVEL_WIDTH-1:0] level_i,
  input  logic                                tx_i,
  input  logic                                advance_i,
  output dciq_pkg::srch_state_t               state_o,
  output logic                                pend_o,
  output logic                                ignored_o
);

  typedef struct packed {
    logic signed [dciq_pkg::SWEEP_W-1:0] value;
    logic signed [dciq_pkg::SWEEP_W-1:0] stop;
    logic [dciq_pkg::STEP_W-1:0]         step;
  } sweep_t;

  localparam int XW = dciq_pkg::SWEEP_W + 1;

  dciq_pkg::srch_state_t                 st_r, st_nxt;
  logic signed [dciq_pkg::SWEEP_W-1:0]   stop_r, stop_nxt;
  logic [dciq_pkg::STEP_W-1:0]           step_r, step_nxt;
  logic signed [dciq_pkg::LEVEL_WIDTH-1:0] best_level_r, best_level_nxt;
  logic                                  pend_r, pend_nxt;
  logic                                  ign_r, ign_nxt;

  dciq_pkg::trial_t                      t;
  logic signed [dciq_pkg::SWEEP_W-1:0]   sv;
  logic signed [XW-1:0]                  sv_inc;
  logic signed [XW-1:0]                  stop_x;
  logic                                  better;
  sweep_t                                sw;

  // window for the next pass: full range when coarse, +-fine span around best when fine
  function automatic sweep_t setup_pass(
    dciq_pkg::phase_t                     ph,
    logic [dciq_pkg::PASS_W-1:0]          p,
    logic signed [dciq_pkg::DC_W-1:0]     bdi,
    logic signed [dciq_pkg::DC_W-1:0]     bdq,
    logic signed [dciq_pkg::IQ_W-1:0]     bg,
    logic signed [dciq_pkg::IQ_W-1:0]     bp,
    logic                                 tx
  );
    logic signed [XW-1:0] lim;
    logic signed [XW-1:0] center;
    logic signed [XW-1:0] lo;
    logic signed [XW-1:0] hi;
    sweep_t               r;
    if (ph == dciq_pkg::PH_DC) begin
      lim    = tx ? XW'(dciq_pkg::DC_SCALE_TX) : XW'(dciq_pkg::DC_SCALE_RX);
      center = p[0] ? XW'(bdi) : XW'(bdq);
    end else begin
      lim    = XW'(dciq_pkg::IQ_RANGE);
      center = p[0] ? XW'(bp) : XW'(bg);
    end
    if ({1'b0, p} < (dciq_pkg::PASS_W + 1)'(2)) begin
      lo     = -lim;
      r.value = lo[dciq_pkg::SWEEP_W-1:0];
      r.stop  = lim[dciq_pkg::SWEEP_W-1:0];
      r.step  = dciq_pkg::STEP_W'(dciq_pkg::COARSE_STEP);
    end else begin
      lo = center - XW'(dciq_pkg::FINE_SPAN);
      if (lo < -lim) begin
        lo = -lim;
      end
      hi = center + XW'(dciq_pkg::FINE_SPAN);
      if (hi > lim) begin
        hi = lim;
      end
      // empty window still tries its start value
      if (hi <= lo) begin
        hi = lo + XW'(1);
      end
      r.value = lo[dciq_pkg::SWEEP_W-1:0];
      r.stop  = hi[dciq_pkg::SWEEP_W-1:0];
      r.step  = dciq_pkg::STEP_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    st_nxt         = st_r;
    stop_nxt       = stop_r;
    step_nxt       = step_r;
    best_level_nxt = best_level_r;
    ign_nxt        = ign_r;
    pend_nxt       = accept_i ? 1'b1 : (advance_i ? 1'b0 : pend_r);
    sw             = '0;

    t      = dciq_pkg::trial(st_r);
    sv     = st_r.sweep;
    stop_x = XW'(stop_r);
    sv_inc = XW'(sv) + XW'(signed'({1'b0, step_r}));
    better = level_i < best_level_r;

    if (accept_i) begin
      ign_nxt = 1'b0;
      if (action_i == dciq_pkg::ACT_START) begin
        st_nxt.phase      = dciq_pkg::PH_DC;
        st_nxt.pass       = '0;
        st_nxt.best_dc_i  = '0;
        st_nxt.best_dc_q  = '0;
        st_nxt.best_gain  = '0;
        st_nxt.best_phase = '0;
        best_level_nxt    = '0;
        sw = setup_pass(dciq_pkg::PH_DC, '0, '0, '0, '0, '0, tx_i);
        st_nxt.sweep = sw.value;
        stop_nxt     = sw.stop;
        step_nxt     = sw.step;
      end else if (st_r.phase != dciq_pkg::PH_DC && st_r.phase != dciq_pkg::PH_IQ) begin
        ign_nxt = 1'b1;
      end else begin
        if (better) begin
          best_level_nxt = level_i;
          if (st_r.phase == dciq_pkg::PH_DC) begin
            st_nxt.best_dc_i = t.dc_i;
            st_nxt.best_dc_q = t.dc_q;
          end else begin
            st_nxt.best_gain  = t.gain;
            st_nxt.best_phase = t.phase;
          end
        end
        if (sv_inc >= stop_x) begin
          if (st_r.pass == dciq_pkg::PASS_W'(dciq_pkg::PASSES - 1)) begin
            st_nxt.pass = '0;
            if (st_r.phase == dciq_pkg::PH_DC) begin
              st_nxt.phase   = dciq_pkg::PH_IQ;
              best_level_nxt = '0;
              sw = setup_pass(dciq_pkg::PH_IQ, '0, st_nxt.best_dc_i, st_nxt.best_dc_q,
                              st_nxt.best_gain, st_nxt.best_phase, tx_i);
              st_nxt.sweep = sw.value;
              stop_nxt     = sw.stop;
              step_nxt     = sw.step;
            end else begin
              st_nxt.phase = dciq_pkg::PH_DONE;
              st_nxt.sweep = '0;
              stop_nxt     = '0;
              step_nxt     = dciq_pkg::STEP_W'(dciq_pkg::COARSE_STEP);
            end
          end else begin
            st_nxt.pass = st_r.pass + 1'b1;
            // best level starts over for the fine passes
            if ({1'b0, st_nxt.pass} == (dciq_pkg::PASS_W + 1)'(2)) begin
              best_level_nxt = '0;
            end
            sw = setup_pass(st_r.phase, st_nxt.pass, st_nxt.best_dc_i, st_nxt.best_dc_q,
                            st_nxt.best_gain, st_nxt.best_phase, tx_i);
            st_nxt.sweep = sw.value;
            stop_nxt     = sw.stop;
            step_nxt     = sw.step;
          end
        end else begin
          st_nxt.sweep = sv_inc[dciq_pkg::SWEEP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= dciq_pkg::PH_IDLE;
      st_r.pass       <= '0;
      st_r.sweep      <= '0;
      st_r.best_dc_i  <= '0;
      st_r.best_dc_q  <= '0;
      st_r.best_gain  <= '0;
      st_r.best_phase <= '0;
      stop_r          <= '0;
      step_r          <= dciq_pkg::STEP_W'(dciq_pkg::COARSE_STEP);
      best_level_r    <= '0;
      pend_r          <= 1'b0;
      ign_r           <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      stop_r       <= stop_nxt;
      step_r       <= step_nxt;
      best_level_r <= best_level_nxt;
      pend_r       <= pend_nxt;
      ign_r        <= ign_nxt;
    end
  end

  assign state_o   = st_r;
  assign pend_o    = pend_r;
  assign ignored_o = ign_r;

endmodule

// ===== src/dciq_out.sv =====
// result encoder and output register with valid/stall handshake
module dciq_out (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   pend_i,
  input  logic                                   ignored_i,
  input  dciq_pkg::srch_state_t                  state_i,
  input  logic                                   tx_i,
  input  logic                                   out_stall,
  output logic                                   advance_o,
  output logic                                   out_valid,
  output logic [1:0]                             out_phase,
  output logic signed [dciq_pkg::DC_W-1:0]       out_dc_i,
  output logic signed [dciq_pkg::DC_W-1:0]       out_dc_q,
  output logic signed [dciq_pkg::IQ_W-1:0]       out_gain_corr,
  output logic signed [dciq_pkg::IQ_W-1:0]       out_phase_corr,
  output logic [dciq_pkg::GAIN_WORD_W-1:0]       out_gain_word_i,
  output logic [dciq_pkg::GAIN_WORD_W-1:0]       out_gain_word_q,
  output logic [dciq_pkg::DC_WORD_W-1:0]         out_dc_word_i,
  output logic [dciq_pkg::DC_WORD_W-1:0]         out_dc_word_q,
  output logic                                   out_ignored
);

  logic                                   valid_r, valid_nxt;
  logic                                   load;
  dciq_pkg::trial_t                       t;
  logic signed [dciq_pkg::IQ_W-1:0]       g;
  logic signed [dciq_pkg::IQ_W:0]         gx;
  logic [dciq_pkg::IQ_W:0]                mag;
  logic [dciq_pkg::GAIN_WORD_W-1:0]       gwi, gwq;
  logic [dciq_pkg::DC_WORD_W-1:0]         dwi, dwq;

  logic [1:0]                             phase_r;
  logic signed [dciq_pkg::DC_W-1:0]       dc_i_r, dc_q_r;
  logic signed [dciq_pkg::IQ_W-1:0]       gain_r, phc_r;
  logic [dciq_pkg::GAIN_WORD_W-1:0]       gwi_r, gwq_r;
  logic [dciq_pkg::DC_WORD_W-1:0]         dwi_r, dwq_r;
  logic                                   ign_r;

  // receive dc encoding: sign bit ored with magnitude
  function automatic logic [dciq_pkg::DC_WORD_W-1:0] rx_word(
    logic signed [dciq_pkg::DC_W-1:0] v
  );
    logic signed [dciq_pkg::DC_W:0] neg;
    neg = -((dciq_pkg::DC_W + 1)'(v));
    if (v < 0) begin
      return dciq_pkg::DC_WORD_W'(dciq_pkg::RX_SIGN_BIT) | neg[dciq_pkg::DC_WORD_W-1:0];
    end
    return v[dciq_pkg::DC_WORD_W-1:0];
  endfunction

  always_comb begin
    t   = dciq_pkg::trial(state_i);
    g   = t.gain;
    gx  = (dciq_pkg::IQ_W + 1)'(g);
    mag = gx[dciq_pkg::IQ_W] ? -gx : gx;
    gwi = dciq_pkg::GAIN_WORD_W'(dciq_pkg::GAIN_FULL);
    gwq = dciq_pkg::GAIN_WORD_W'(dciq_pkg::GAIN_FULL);
    if (g < 0) begin
      gwi = dciq_pkg::GAIN_WORD_W'(dciq_pkg::GAIN_FULL) - dciq_pkg::GAIN_WORD_W'(mag);
    end
    if (g > 0) begin
      gwq = dciq_pkg::GAIN_WORD_W'(dciq_pkg::GAIN_FULL) - dciq_pkg::GAIN_WORD_W'(mag);
    end
    // transmit path has no dc word
    dwi = tx_i ? '0 : rx_word(t.dc_i);
    dwq = tx_i ? '0 : rx_word(t.dc_q);
  end

  assign advance_o = !valid_r || !out_stall;
  assign load      = pend_i && advance_o;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      phase_r <= state_i.phase;
      dc_i_r  <= t.dc_i;
      dc_q_r  <= t.dc_q;
      gain_r  <= t.gain;
      phc_r   <= t.phase;
      gwi_r   <= gwi;
      gwq_r   <= gwq;
      dwi_r   <= dwi;
      dwq_r   <= dwq;
      ign_r   <= ignored_i;
    end
  end

  assign out_valid       = valid_r;
  assign out_phase       = phase_r;
  assign out_dc_i        = dc_i_r;
  assign out_dc_q        = dc_q_r;
  assign out_gain_corr   = gain_r;
  assign out_phase_corr  = phc_r;
  assign out_gain_word_i = gwi_r;
  assign out_gain_word_q = gwq_r;
  assign out_dc_word_i   = dwi_r;
  assign out_dc_word_q   = dwq_r;
  assign out_ignored     = ign_r;

endmodule

// ===== src/dc_iq_calibration_search.sv =====
// top level of the dc-offset and iq-imbalance calibration search sequencer
//
// usage: software sends a start transaction (action 0) and applies the returned
// dc_i/dc_q/gain/phase settings (plus the encoded gain and dc register words),
// waits for the radio to settle, measures the tone and sends the level back
// as a measure transaction (action 1). each measure transaction returns the next
// setting to try; phase walks dc sweep -> iq sweep -> done.
// channels: in_* and out_* use valid/stall; a transaction moves when valid is
// high and stall is low. direction_is_tx is written over the apb port at
// address 0; software writes it only while the block is idle, which the block does not enforce.
// path: an input transaction updates the search state register, then its result is
// loaded into the output register. throughput: one transaction per cycle while the
// output is not stalled, set by the search state update.
// stall: the output register holds while out_stall is high; one more input
// transaction is taken and held in the search registers, after which in_stall
// goes high until the output drains.
// reset: synchronous active-low rst_n returns to idle with all best values zero,
// receive direction selected and no result pending.
module dc_iq_calibration_search (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_action,
  input  logic signed [dciq_pkg::LEVEL_WIDTH-1:0] in_level,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             out_phase,
  output logic signed [dciq_pkg::DC_W-1:0]       out_dc_i,
  output logic signed [dciq_pkg::DC_W-1:0]       out_dc_q,
  output logic signed [dciq_pkg::IQ_W-1:0]       out_gain_corr,
  output logic signed [dciq_pkg::IQ_W-1:0]       out_phase_corr,
  output logic [dciq_pkg::GAIN_WORD_W-1:0]       out_gain_word_i,
  output logic [dciq_pkg::GAIN_WORD_W-1:0]       out_gain_word_q,
  output logic [dciq_pkg::DC_WORD_W-1:0]         out_dc_word_i,
  output logic [dciq_pkg::DC_WORD_W-1:0]         out_dc_word_q,
  output logic                                   out_ignored,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [dciq_pkg::CFG_AW-1:0]            paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  logic                  tx_r, tx_nxt;
  logic                  cfg_hit;
  logic                  cfg_wr;
  logic                  in_accept;
  logic                  advance;
  logic                  pend;
  logic                  pend_ign;
  dciq_pkg::srch_state_t srch_state;

  // single register: direction select at word 0
  assign cfg_hit = paddr[dciq_pkg::CFG_AW-1:2] == dciq_pkg::REG_DIRECTION;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign tx_nxt  = (cfg_wr && cfg_hit) ? pwdata[0] : tx_r;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? {31'd0, tx_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r <= 1'b0;
    end else begin
      tx_r <= tx_nxt;
    end
  end

  // hold off input only when a result waits in the search stage and the
  // output register is full and stalled
  assign in_stall  = pend && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  dciq_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept_i  (in_accept),
    .action_i  (in_action),
    .level_i   (in_level),
    .tx_i      (tx_r),
    .advance_i (advance),
    .state_o   (srch_state),
    .pend_o    (pend),
    .ignored_o (pend_ign)
  );

  dciq_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .pend_i          (pend),
    .ignored_i       (pend_ign),
    .state_i         (srch_state),
    .tx_i            (tx_r),
    .out_stall       (out_stall),
    .advance_o       (advance),
    .out_valid       (out_valid),
    .out_phase       (out_phase),
    .out_dc_i        (out_dc_i),
    .out_dc_q        (out_dc_q),
    .out_gain_corr   (out_gain_corr),
    .out_phase_corr  (out_phase_corr),
    .out_gain_word_i (out_gain_word_i),
    .out_gain_word_q (out_gain_word_q),
    .out_dc_word_i   (out_dc_word_i),
    .out_dc_word_q   (out_dc_word_q),
    .out_ignored     (out_ignored)
  );

  // a start transaction always lands the search in the dc phase
  a_start_dc: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_action == dciq_pkg::ACT_START |=> srch_state.phase == dciq_pkg::PH_DC)
    else $error("start transaction did not enter dc phase");

  // idle is reported only for a measurement that arrived before any start
  a_idle_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == dciq_pkg::PH_IDLE |-> out_ignored)
    else $error("idle result not flagged as ignored");

  // during the dc sweep no iq correction is applied
  a_dc_no_iq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == dciq_pkg::PH_DC |-> out_gain_corr == '0 && out_phase_corr == '0)
    else $error("iq correction nonzero during dc sweep");

  // a pending result is never dropped: it either moves out or stays pending
  a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
    pend && !advance |=> pend)
    else $error("pending result lost while output stalled");

endmodule

// ===== verif/dciq_search_checker.sv =====
// checker for the dc/iq calibration search: predicts each result and compares it
module dciq_search_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic                                    in_action,
  input  logic signed [dciq_pkg::LEVEL_WIDTH-1:0] in_level,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic [1:0]                              out_phase,
  input  logic signed [dciq_pkg::DC_W-1:0]        out_dc_i,
  input  logic signed [dciq_pkg::DC_W-1:0]        out_dc_q,
  input  logic signed [dciq_pkg::IQ_W-1:0]        out_gain_corr,
  input  logic signed [dciq_pkg::IQ_W-1:0]        out_phase_corr,
  input  logic [dciq_pkg::GAIN_WORD_W-1:0]        out_gain_word_i,
  input  logic [dciq_pkg::GAIN_WORD_W-1:0]        out_gain_word_q,
  input  logic [dciq_pkg::DC_WORD_W-1:0]          out_dc_word_i,
  input  logic [dciq_pkg::DC_WORD_W-1:0]          out_dc_word_q,
  input  logic                                    out_ignored,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [dciq_pkg::CFG_AW-1:0]             paddr,
  input  logic [31:0]                             pwdata,
  input  logic                                    pready,
  output int                                      fail_count,
  output int                                      pending,
  output int                                      checked
);

  typedef struct {
    logic [1:0]                       ph;
    logic signed [dciq_pkg::DC_W-1:0] dc_i;
    logic signed [dciq_pkg::DC_W-1:0] dc_q;
    logic signed [dciq_pkg::IQ_W-1:0] gain;
    logic signed [dciq_pkg::IQ_W-1:0] phs;
    logic [dciq_pkg::GAIN_WORD_W-1:0] gw_i;
    logic [dciq_pkg::GAIN_WORD_W-1:0] gw_q;
    logic [dciq_pkg::DC_WORD_W-1:0]   dw_i;
    logic [dciq_pkg::DC_WORD_W-1:0]   dw_q;
    logic                             ign;
  } cal_setting_t;

  cal_setting_t pending_settings[$];

  // own copy of the search registers
  logic             dir_tx;
  dciq_pkg::phase_t srch_ph;
  int               pass_no;
  int               sweep_val;
  int               sweep_end;
  int               sweep_inc;
  int               best_lvl;
  int               bdi;
  int               bdq;
  int               bg;
  int               bp;
  int               fails;
  int               nchecked;

  function automatic void clear_search();
    srch_ph   = dciq_pkg::PH_IDLE;
    pass_no   = 0;
    sweep_val = 0;
    sweep_end = 0;
    sweep_inc = dciq_pkg::COARSE_STEP;
    best_lvl  = 0;
    bdi       = 0;
    bdq       = 0;
    bg        = 0;
    bp        = 0;
  endfunction

  // window of the pass that pass_no points at
  function automatic void plan_pass();
    int lim;
    int center;
    int lo;
    int hi;
    if (srch_ph == dciq_pkg::PH_DC) begin
      lim    = dir_tx ? dciq_pkg::DC_SCALE_TX : dciq_pkg::DC_SCALE_RX;
      center = (pass_no % 2 == 0) ? bdq : bdi;
    end else begin
      lim    = dciq_pkg::IQ_RANGE;
      center = (pass_no % 2 == 0) ? bg : bp;
    end
    if (pass_no < 2) begin
      sweep_val = -lim;
      sweep_end = lim;
      sweep_inc = dciq_pkg::COARSE_STEP;
    end else begin
      if (pass_no == 2) best_lvl = 0;
      lo = center - dciq_pkg::FINE_SPAN;
      if (lo < -lim) lo = -lim;
      hi = center + dciq_pkg::FINE_SPAN;
      if (hi > lim) hi = lim;
      if (hi <= lo) hi = lo + 1;
      sweep_val = lo;
      sweep_end = hi;
      sweep_inc = 1;
    end
  endfunction

  function automatic void try_setting(output int di, output int dq, output int g, output int p);
    di = bdi;
    dq = bdq;
    g  = bg;
    p  = bp;
    if (srch_ph == dciq_pkg::PH_DC) begin
      g = 0;
      p = 0;
      if (pass_no % 2 == 0) dq = sweep_val;
      else di = sweep_val;
    end else if (srch_ph == dciq_pkg::PH_IQ) begin
      if (pass_no % 2 == 0) g = sweep_val;
      else p = sweep_val;
    end
  endfunction

  function automatic logic [dciq_pkg::DC_WORD_W-1:0] rx_dc_word(int v);
    if (v < 0) return dciq_pkg::DC_WORD_W'(dciq_pkg::RX_SIGN_BIT | -v);
    return dciq_pkg::DC_WORD_W'(v);
  endfunction

  function automatic cal_setting_t make_setting(logic ign);
    cal_setting_t s;
    int di;
    int dq;
    int g;
    int p;
    int mag;
    try_setting(di, dq, g, p);
    mag    = (g < 0) ? -g : g;
    s.ph   = srch_ph;
    s.dc_i = di[dciq_pkg::DC_W-1:0];
    s.dc_q = dq[dciq_pkg::DC_W-1:0];
    s.gain = g[dciq_pkg::IQ_W-1:0];
    s.phs  = p[dciq_pkg::IQ_W-1:0];
    s.gw_i = (g < 0) ? dciq_pkg::GAIN_WORD_W'(dciq_pkg::GAIN_FULL - mag)
                     : dciq_pkg::GAIN_WORD_W'(dciq_pkg::GAIN_FULL);
    s.gw_q = (g > 0) ? dciq_pkg::GAIN_WORD_W'(dciq_pkg::GAIN_FULL - mag)
                     : dciq_pkg::GAIN_WORD_W'(dciq_pkg::GAIN_FULL);
    s.dw_i = dir_tx ? '0 : rx_dc_word(di);
    s.dw_q = dir_tx ? '0 : rx_dc_word(dq);
    s.ign  = ign;
    return s;
  endfunction

  // advance the search by one transaction and return the setting it produces
  function automatic cal_setting_t next_setting(logic act, int lvl);
    int di;
    int dq;
    int g;
    int p;
    if (act == dciq_pkg::ACT_START) begin
      clear_search();
      srch_ph = dciq_pkg::PH_DC;
      plan_pass();
      return make_setting(1'b0);
    end
    if (srch_ph != dciq_pkg::PH_DC && srch_ph != dciq_pkg::PH_IQ) return make_setting(1'b1);
    try_setting(di, dq, g, p);
    if (lvl < best_lvl) begin
      best_lvl = lvl;
      if (srch_ph == dciq_pkg::PH_DC) begin
        bdi = di;
        bdq = dq;
      end else begin
        bg = g;
        bp = p;
      end
    end
    sweep_val += sweep_inc;
    if (sweep_val >= sweep_end) begin
      pass_no++;
      if (pass_no >= dciq_pkg::PASSES) begin
        pass_no = 0;
        if (srch_ph == dciq_pkg::PH_DC) begin
          srch_ph  = dciq_pkg::PH_IQ;
          best_lvl = 0;
          plan_pass();
        end else begin
          srch_ph   = dciq_pkg::PH_DONE;
          sweep_val = 0;
          sweep_end = 0;
          sweep_inc = dciq_pkg::COARSE_STEP;
        end
      end else begin
        plan_pass();
      end
    end
    return make_setting(1'b0);
  endfunction

  // signed fields sign-extend and unsigned ones zero-extend on both sides
  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    cal_setting_t want;
    cal_setting_t exp_set;
    if (!rst_n) begin
      dir_tx = 1'b0;
      clear_search();
      pending_settings.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == dciq_pkg::CFG_AW'(4 * dciq_pkg::REG_DIRECTION))
        dir_tx = pwdata[0];
      if (out_valid && !out_stall) begin
        if (pending_settings.size() == 0) begin
          $error("result transaction with no input transaction waiting");
          fails++;
        end else begin
          want = pending_settings.pop_front();
          nchecked++;
          check_field("phase", want.ph, out_phase);
          check_field("dc_i", want.dc_i, out_dc_i);
          check_field("dc_q", want.dc_q, out_dc_q);
          check_field("gain_corr", want.gain, out_gain_corr);
          check_field("phase_corr", want.phs, out_phase_corr);
          check_field("gain_word_i", want.gw_i, out_gain_word_i);
          check_field("gain_word_q", want.gw_q, out_gain_word_q);
          check_field("dc_word_i", want.dw_i, out_dc_word_i);
          check_field("dc_word_q", want.dw_q, out_dc_word_q);
          check_field("ignored", want.ign, out_ignored);
        end
      end
      if (in_valid && !in_stall) begin
        exp_set = next_setting(in_action, int'(in_level));
        pending_settings.insert(pending_settings.size(), exp_set);
      end
    end
    pending    <= pending_settings.size();
    fail_count <= fails;
    checked    <= nchecked;
  end

endmodule

// ===== verif/tb_dc_iq_calibration_search.sv =====
// testbench top for the dc/iq calibration search: stimulus, idling and verdict
module tb_dc_iq_calibration_search;

  localparam int QUIET_LIMIT = 4000;   // cycles with no transaction before giving up
  localparam int TOTAL_ITEMS = 1900;   // includes measurements that land while done
  localparam int FULL_SEARCH = 430;    // enough measurements to run any search to done
  localparam int LVL_W       = dciq_pkg::LEVEL_WIDTH;

  // level profiles
  localparam int PROF_MIXED     = 0;   // random mix
  localparam int PROF_FALLING   = 1;   // steadily falling
  localparam int PROF_EARLY_MIN = 2;   // lowest at the very first trial

  logic                                    clk = 1'b0;
  logic                                    rst_n = 1'b0;
  logic                                    in_valid = 1'b0;
  logic                                    in_stall;
  logic                                    in_action = dciq_pkg::ACT_START;
  logic signed [LVL_W-1:0]                 in_level = '0;
  logic                                    out_valid;
  logic                                    out_stall = 1'b0;
  logic [1:0]                              out_phase;
  logic signed [dciq_pkg::DC_W-1:0]        out_dc_i;
  logic signed [dciq_pkg::DC_W-1:0]        out_dc_q;
  logic signed [dciq_pkg::IQ_W-1:0]        out_gain_corr;
  logic signed [dciq_pkg::IQ_W-1:0]        out_phase_corr;
  logic [dciq_pkg::GAIN_WORD_W-1:0]        out_gain_word_i;
  logic [dciq_pkg::GAIN_WORD_W-1:0]        out_gain_word_q;
  logic [dciq_pkg::DC_WORD_W-1:0]          out_dc_word_i;
  logic [dciq_pkg::DC_WORD_W-1:0]          out_dc_word_q;
  logic                                    out_ignored;
  logic                                    psel = 1'b0;
  logic                                    penable = 1'b0;
  logic                                    pwrite = 1'b0;
  logic [dciq_pkg::CFG_AW-1:0]             paddr = '0;
  logic [31:0]                             pwdata = '0;
  logic [31:0]                             prdata;
  logic                                    pready;

  int fail_count;
  int pending;
  int checked;
  int sent = 0;
  int send_idle = 0;    // percent of cycles the sender holds off before a transaction
  int recv_idle = 0;    // percent of cycles the receiver stalls
  int quiet = 0;

  dc_iq_calibration_search DUT (.*);

  dciq_search_checker u_checker (.*);

  always #5 clk = ~clk;

  // receiver: random stall at the rate of the current idling segment
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  // watchdog: any transaction on either channel or the apb port restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // one input transaction; valid stays high into the next call unless it idles
  task automatic send_item(input logic act, input logic signed [LVL_W-1:0] lvl);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_level  <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // search and output register pipeline, give it a little slack
    repeat (4) @(posedge clk);
  endtask

  // direction register write over apb, only with the block drained
  task automatic write_direction(input logic tx);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dciq_pkg::CFG_AW'(4 * dciq_pkg::REG_DIRECTION);
    // upper bits are don't-care for a one-bit register, keep them noisy
    pwdata  <= ($urandom() & ~32'd1) | 32'(tx);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [LVL_W-1:0] pick_level(int mode, int k);
    int r;
    r = $urandom_range(99);
    case (mode)
      PROF_FALLING: return LVL_W'(-k - 1);
      PROF_EARLY_MIN: return (k == 0) ? LVL_W'(-32768) : LVL_W'($urandom_range(32767));
      default: begin
        if (r < 50) return LVL_W'(-$urandom_range(400));
        if (r < 70) return LVL_W'($urandom());
        if (r < 80) begin
          case ($urandom_range(3))
            0: return LVL_W'(-32768);
            1: return LVL_W'(32767);
            2: return LVL_W'(-1);
            default: return '0;
          endcase
        end
        return LVL_W'($urandom_range(1000));
      end
    endcase
  endfunction

  task automatic run_search(input int mode, input int n_meas);
    send_item(dciq_pkg::ACT_START, LVL_W'($urandom()));
    for (int k = 0; k < n_meas; k++) send_item(dciq_pkg::ACT_MEASURE, pick_level(mode, k));
  endtask

  initial begin
    int seg;
    int mode;
    int n_meas;
    seg = 0;
    // segment 0: sender mostly busy, receiver stalls a lot
    send_idle = 11;
    recv_idle <= 78;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, receive direction ----
    write_direction(1'b0);
    // measurements before any start are ignored
    send_item(dciq_pkg::ACT_MEASURE, LVL_W'(-32768));
    send_item(dciq_pkg::ACT_MEASURE, LVL_W'(32767));
    // level on a start transaction does not matter
    send_item(dciq_pkg::ACT_START, LVL_W'(32767));
    send_item(dciq_pkg::ACT_MEASURE, LVL_W'(-32768));
    send_item(dciq_pkg::ACT_MEASURE, LVL_W'(32767));
    send_item(dciq_pkg::ACT_MEASURE, LVL_W'(-32768));   // tie with best, no update
    send_item(dciq_pkg::ACT_MEASURE, LVL_W'(-1));
    // restart in the middle of a search
    send_item(dciq_pkg::ACT_START, LVL_W'(-32768));
    send_item(dciq_pkg::ACT_MEASURE, '0);               // equal to the cleared best
    send_item(dciq_pkg::ACT_MEASURE, LVL_W'(-1));
    send_item(dciq_pkg::ACT_MEASURE, LVL_W'(-2));

    // ---- directed part, transmit direction: wider dc scale, dc words forced to zero ----
    write_direction(1'b1);
    send_item(dciq_pkg::ACT_START, '0);
    send_item(dciq_pkg::ACT_MEASURE, LVL_W'(-5));
    send_item(dciq_pkg::ACT_MEASURE, LVL_W'(-6));
    send_item(dciq_pkg::ACT_MEASURE, LVL_W'(32767));
    send_item(dciq_pkg::ACT_MEASURE, LVL_W'(-32768));

    // direction flips mid-search: falling levels push the best dc values up to 120
    // in transmit scale, then the receive scale leaves the last fine window empty
    send_item(dciq_pkg::ACT_START, '0);
    for (int k = 0; k < 70; k++) send_item(dciq_pkg::ACT_MEASURE, pick_level(PROF_FALLING, k));
    write_direction(1'b0);
    for (int k = 70; k < 70 + FULL_SEARCH; k++)
      send_item(dciq_pkg::ACT_MEASURE, pick_level(PROF_FALLING, k));

    while (sent < TOTAL_ITEMS) begin
      mode = $urandom_range(PROF_EARLY_MIN);
      // most searches run to done and then see a few ignored measurements,
      // the rest are cut short by the next start
      n_meas = ($urandom_range(4) == 0) ? $urandom_range(1, 300) : FULL_SEARCH;
      // the last search is trimmed so the run ends on the item count
      if (n_meas > TOTAL_ITEMS - sent - 1) n_meas = TOTAL_ITEMS - sent - 1;
      run_search(mode, n_meas);
      if (seg == 0 && sent >= 700) begin
        // segment 1: sender idles a lot, receiver rarely stalls
        write_direction(1'b1);
        seg = 1;
        send_idle = 78;
        recv_idle <= 11;
      end else if (seg == 1 && sent >= 1400) begin
        // segment 2: no idling on either side
        write_direction(1'b0);
        seg = 2;
        send_idle = 0;
        recv_idle <= 0;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("run covered %0d input transactions and %0d checked results", sent, checked);
    $display("both directions, mid-search restarts and direction change, searches to done");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
